>>> hw/rtl/multi_bus_gain_smoother_assert.svh
// Assertion macros shared by the gain smoother RTL.
`ifndef MULTI_BUS_GAIN_SMOOTHER_ASSERT_SVH
`define MULTI_BUS_GAIN_SMOOTHER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge outside reset.
`define MBGS_ASSERT_IMPL(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("mbgs assertion failed");
// Next-cycle implication.
`define MBGS_ASSERT_NEXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("mbgs assertion failed");
`else
`define MBGS_ASSERT_IMPL(label, lhs, rhs)
`define MBGS_ASSERT_NEXT(label, lhs, rhs)
`endif
`endif

>>> hw/rtl/mbgs_pkg.sv
// Shared types and constants of the gain smoother.
package mbgs_pkg;

  localparam int NUM_BUSES_DEF    = 8;
  localparam int MASTER_INDEX_DEF = 0;
  localparam int QUEUE_DEPTH      = 2;

  localparam int GAIN_W = 16;
  localparam int BUS_W  = 4;
  localparam int CMD_W  = 3;
  localparam int IN_W   = 40;
  localparam int OUT_W  = 56;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd16384;

  // Raw command codes as they arrive on the input word.
  localparam logic [CMD_W-1:0] CMD_SET_TARGET    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET_IMMEDIATE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_MUTE      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TICK          = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY         = 3'd4;

  // Register index, taken from the word address.
  localparam logic REG_MIN_GAIN = 1'b0;
  localparam logic REG_MAX_GAIN = 1'b1;

  typedef enum logic [2:0] {
    OP_TARGET,
    OP_IMMEDIATE,
    OP_MUTE,
    OP_TICK,
    OP_QUERY
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK,
    ST_TICK_END,
    ST_EFF,
    ST_RES
  } back_state_t;

  // One classified command as it waits in the queue.
  typedef struct packed {
    op_t               op;
    logic [BUS_W-1:0]  bus;
    logic              bus_valid;
    logic              is_master;
    logic [GAIN_W-1:0] gain;
    logic              mute;
    logic [GAIN_W-1:0] alpha;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> hw/rtl/mbgs_front.sv
// Front end: accepts command words, decodes them and clamps written gains.
module mbgs_front #(
  parameter int NUM_BUSES    = mbgs_pkg::NUM_BUSES_DEF,
  parameter int MASTER_INDEX = mbgs_pkg::MASTER_INDEX_DEF
) (
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [mbgs_pkg::IN_W-1:0]    in_tdata,
  input  logic [mbgs_pkg::GAIN_W-1:0]  min_gain,
  input  logic [mbgs_pkg::GAIN_W-1:0]  max_gain,
  input  mbgs_pkg::queue_status_t      q_status,
  output logic                         push,
  output mbgs_pkg::item_t              push_item
);

  logic [mbgs_pkg::CMD_W-1:0]  cmd;
  logic [mbgs_pkg::BUS_W-1:0]  bus;
  logic [mbgs_pkg::GAIN_W-1:0] gain_raw;
  logic [mbgs_pkg::GAIN_W-1:0] gain_lo;
  logic                        valid_bus;

  assign cmd       = in_tdata[2:0];
  assign bus       = in_tdata[6:3];
  assign gain_raw  = in_tdata[22:7];
  assign valid_bus = ({1'b0, bus} < 5'(NUM_BUSES));

  assign in_tready = !q_status.full;
  assign push      = in_tvalid && !q_status.full;

  // Floor first, then ceiling, so an inverted pair yields the ceiling.
  assign gain_lo = (gain_raw < min_gain) ? min_gain : gain_raw;

  always_comb begin
    push_item           = '0;
    push_item.bus       = valid_bus ? bus : '0;
    push_item.bus_valid = valid_bus;
    push_item.is_master = (bus == mbgs_pkg::BUS_W'(MASTER_INDEX));
    push_item.gain      = (gain_lo > max_gain) ? max_gain : gain_lo;
    push_item.mute      = in_tdata[23];
    push_item.alpha     = in_tdata[39:24];
    case (cmd)
      mbgs_pkg::CMD_SET_TARGET:    push_item.op = mbgs_pkg::OP_TARGET;
      mbgs_pkg::CMD_SET_IMMEDIATE: push_item.op = mbgs_pkg::OP_IMMEDIATE;
      mbgs_pkg::CMD_SET_MUTE:      push_item.op = mbgs_pkg::OP_MUTE;
      mbgs_pkg::CMD_TICK:          push_item.op = mbgs_pkg::OP_TICK;
      mbgs_pkg::CMD_QUERY:         push_item.op = mbgs_pkg::OP_QUERY;
      default:                     push_item.op = mbgs_pkg::OP_QUERY;
    endcase
  end

endmodule

>>> hw/rtl/mbgs_queue.sv
// Short command queue between the front end and the bus engine.
module mbgs_queue #(
  parameter int DEPTH = mbgs_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  mbgs_pkg::item_t         push_item,
  input  logic                    pop,
  output mbgs_pkg::item_t         head,
  output mbgs_pkg::queue_status_t status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mbgs_pkg::item_t mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign status.full  = (cnt_r == CW'(DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> hw/rtl/mbgs_back.sv
// Bus engine: holds the bus bank, runs ticks and effective-gain products
// through one shared multiplier, and registers the result word.
module mbgs_back #(
  parameter int NUM_BUSES    = mbgs_pkg::NUM_BUSES_DEF,
  parameter int MASTER_INDEX = mbgs_pkg::MASTER_INDEX_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mbgs_pkg::queue_status_t    q_status,
  input  mbgs_pkg::item_t            head,
  output logic                       pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [mbgs_pkg::OUT_W-1:0] out_tdata
);

  localparam int BW        = $clog2(NUM_BUSES);
  localparam bit MASTER_OK = (MASTER_INDEX < NUM_BUSES);
  localparam int MIDX      = MASTER_OK ? MASTER_INDEX : 0;

  mbgs_pkg::back_state_t state_r, state_nxt;
  mbgs_pkg::item_t       item_r;

  logic [mbgs_pkg::GAIN_W-1:0] cur_r  [NUM_BUSES];
  logic [mbgs_pkg::GAIN_W-1:0] tgt_r  [NUM_BUSES];
  logic                        mute_r [NUM_BUSES];

  logic [BW-1:0]               idx_r, idx_nxt;
  logic                        wb_en_r, wb_en_nxt;
  logic [BW-1:0]               wb_idx_r;
  logic [mbgs_pkg::GAIN_W-1:0] wb_cur_r;
  logic signed [34:0]          prod_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [mbgs_pkg::OUT_W-1:0]  out_data_r;

  logic                        apply_set;
  logic                        mul_en;
  logic                        load_out;
  logic [BW-1:0]               rd_idx;
  logic [mbgs_pkg::GAIN_W-1:0] rd_cur;
  logic [mbgs_pkg::GAIN_W-1:0] rd_tgt;
  logic                        rd_mute;
  logic [mbgs_pkg::GAIN_W-1:0] m_cur;
  logic                        m_mute;
  logic [16:0]                 diff;
  logic signed [17:0]          mul_a;
  logic signed [16:0]          mul_b;
  logic signed [34:0]          mul_p;
  logic signed [34:0]          rnd;
  logic [19:0]                 wb_sum;
  logic [mbgs_pkg::GAIN_W-1:0] wb_val;
  logic [31:0]                 eff_rnd;
  logic [mbgs_pkg::GAIN_W-1:0] eff_sat;
  logic [mbgs_pkg::GAIN_W-1:0] eff;
  logic [mbgs_pkg::OUT_W-1:0]  res_word;

  // One read port walks the bank during a tick; otherwise it follows the
  // addressed bus. The master is read at its own fixed place.
  assign rd_idx  = (state_r == mbgs_pkg::ST_TICK) ? idx_r : item_r.bus[BW-1:0];
  assign rd_cur  = cur_r[rd_idx];
  assign rd_tgt  = tgt_r[rd_idx];
  assign rd_mute = mute_r[rd_idx];
  assign m_cur   = MASTER_OK ? cur_r[BW'(MIDX)] : mbgs_pkg::UNITY_GAIN;
  assign m_mute  = MASTER_OK ? mute_r[BW'(MIDX)] : 1'b0;

  assign diff = {1'b0, rd_tgt} - {1'b0, rd_cur};

  always_comb begin
    if (state_r == mbgs_pkg::ST_TICK) begin
      mul_a = {diff[16], diff};
      mul_b = {1'b0, item_r.alpha};
    end else begin
      mul_a = {2'b00, rd_cur};
      mul_b = {1'b0, m_cur};
    end
  end

  assign mul_p = mul_a * mul_b;

  // Tick write-back: current plus floor((d * alpha + 0.5 LSB) / 2^16).
  assign rnd    = prod_r + 35'sd32768;
  assign wb_sum = {4'b0000, wb_cur_r} + {rnd[34], rnd[34:16]};
  always_comb begin
    if (wb_sum[19]) begin
      wb_val = '0;
    end else if (wb_sum[18:16] != 3'b000) begin
      wb_val = '1;
    end else begin
      wb_val = wb_sum[15:0];
    end
  end

  // Effective gain: Q2.14 product rounded half up and saturated.
  assign eff_rnd = prod_r[31:0] + 32'd8192;
  assign eff_sat = (eff_rnd[31:30] != 2'b00) ? '1 : eff_rnd[29:14];

  always_comb begin
    if (rd_mute) begin
      eff = '0;
    end else if (item_r.is_master) begin
      eff = rd_cur;
    end else if (m_mute) begin
      eff = '0;
    end else begin
      eff = eff_sat;
    end
  end

  always_comb begin
    res_word = '0;
    if (item_r.bus_valid) begin
      res_word[0]     = 1'b1;
      res_word[16:1]  = rd_tgt;
      res_word[32:17] = rd_cur;
      res_word[33]    = rd_mute;
      res_word[49:34] = eff;
    end else begin
      res_word[16:1]  = mbgs_pkg::UNITY_GAIN;
      res_word[32:17] = mbgs_pkg::UNITY_GAIN;
      res_word[49:34] = mbgs_pkg::UNITY_GAIN;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mbgs_pkg::ST_IDLE: begin
        if (!q_status.empty) begin
          state_nxt = mbgs_pkg::ST_EXEC;
        end
      end
      mbgs_pkg::ST_EXEC: begin
        state_nxt = (item_r.op == mbgs_pkg::OP_TICK) ? mbgs_pkg::ST_TICK : mbgs_pkg::ST_EFF;
      end
      mbgs_pkg::ST_TICK: begin
        if (idx_r == BW'(NUM_BUSES - 1)) begin
          state_nxt = mbgs_pkg::ST_TICK_END;
        end
      end
      mbgs_pkg::ST_TICK_END: state_nxt = mbgs_pkg::ST_EFF;
      mbgs_pkg::ST_EFF:      state_nxt = mbgs_pkg::ST_RES;
      mbgs_pkg::ST_RES: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = mbgs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mbgs_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    pop       = 1'b0;
    apply_set = 1'b0;
    mul_en    = 1'b0;
    load_out  = 1'b0;
    wb_en_nxt = 1'b0;
    idx_nxt   = idx_r;
    case (state_r)
      mbgs_pkg::ST_IDLE: pop = !q_status.empty;
      mbgs_pkg::ST_EXEC: begin
        apply_set = item_r.bus_valid;
        idx_nxt   = '0;
      end
      mbgs_pkg::ST_TICK: begin
        mul_en    = 1'b1;
        wb_en_nxt = 1'b1;
        idx_nxt   = idx_r + 1'b1;
      end
      mbgs_pkg::ST_EFF: mul_en = 1'b1;
      mbgs_pkg::ST_RES: load_out = !out_valid_r || out_tready;
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mbgs_pkg::ST_IDLE;
      idx_r       <= '0;
      wb_en_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      wb_en_r     <= wb_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= head;
    end
    if (mul_en) begin
      prod_r <= mul_p;
    end
    wb_idx_r <= idx_r;
    wb_cur_r <= rd_cur;
    if (load_out) begin
      out_data_r <= res_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUSES; i++) begin
        cur_r[i]  <= mbgs_pkg::UNITY_GAIN;
        tgt_r[i]  <= mbgs_pkg::UNITY_GAIN;
        mute_r[i] <= 1'b0;
      end
    end else begin
      if (wb_en_r) begin
        cur_r[wb_idx_r] <= wb_val;
      end
      if (apply_set) begin
        case (item_r.op)
          mbgs_pkg::OP_TARGET: tgt_r[item_r.bus[BW-1:0]] <= item_r.gain;
          mbgs_pkg::OP_IMMEDIATE: begin
            cur_r[item_r.bus[BW-1:0]] <= item_r.gain;
            tgt_r[item_r.bus[BW-1:0]] <= item_r.gain;
          end
          mbgs_pkg::OP_MUTE: mute_r[item_r.bus[BW-1:0]] <= item_r.mute;
          default: begin
          end
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> hw/rtl/multi_bus_gain_smoother.sv
// Top level of the multi-bus gain smoother: register port, queue and engine.
//
// A bank of NUM_BUSES gain buses takes one command word at a time and gives
// one result word for each. Set, mute and query commands pass through the
// fetch, apply, multiply and result steps in the bus engine; a smoothing
// tick walks every bus, one per cycle, through the single shared multiplier
// before the result product is formed. A two-word queue in front of the
// engine keeps accepting commands while one is in work, and the result
// register holds a finished word until it is taken. The bus bank is ready
// right after reset. min_gain sits at address 0 and max_gain at 4; they
// should be written only while no command is in flight.
`include "multi_bus_gain_smoother_assert.svh"
module multi_bus_gain_smoother #(
  parameter int NUM_BUSES    = mbgs_pkg::NUM_BUSES_DEF,
  parameter int MASTER_INDEX = mbgs_pkg::MASTER_INDEX_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // [2:0] command, [6:3] bus_index, [22:7] gain_value, [23] mute_value,
  // [39:24] smoothing_step
  input  logic [mbgs_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [0] bus_valid, [16:1] target_gain_out, [32:17] current_gain_out,
  // [33] muted_out, [49:34] effective_gain, [55:50] zero
  output logic [mbgs_pkg::OUT_W-1:0] out_tdata,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [2:0]                 cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  logic [mbgs_pkg::GAIN_W-1:0] min_gain_r;
  logic [mbgs_pkg::GAIN_W-1:0] max_gain_r;
  logic                        cfg_wr;
  logic                        push;
  logic                        pop;
  mbgs_pkg::item_t             push_item;
  mbgs_pkg::item_t             head;
  mbgs_pkg::queue_status_t     q_status;
  logic                        inv_defaults_ok;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == mbgs_pkg::REG_MAX_GAIN) ? {16'h0000, max_gain_r}
                                                               : {16'h0000, min_gain_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_gain_r <= '0;
      max_gain_r <= 16'd32768;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == mbgs_pkg::REG_MIN_GAIN) begin
        min_gain_r <= cfg_pwdata[15:0];
      end else begin
        max_gain_r <= cfg_pwdata[15:0];
      end
    end
  end

  mbgs_front #(
    .NUM_BUSES    (NUM_BUSES),
    .MASTER_INDEX (MASTER_INDEX)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .min_gain  (min_gain_r),
    .max_gain  (max_gain_r),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  mbgs_queue #(
    .DEPTH (mbgs_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  mbgs_back #(
    .NUM_BUSES    (NUM_BUSES),
    .MASTER_INDEX (MASTER_INDEX)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  assign inv_defaults_ok = (out_tdata[16:1] == mbgs_pkg::UNITY_GAIN) &&
                           (out_tdata[32:17] == mbgs_pkg::UNITY_GAIN) &&
                           !out_tdata[33] &&
                           (out_tdata[49:34] == mbgs_pkg::UNITY_GAIN);

  // A result for a missing bus carries the default values.
  `MBGS_ASSERT_IMPL(a_invalid_defaults, out_tvalid && !out_tdata[0], inv_defaults_ok)
  // A muted bus never passes any gain.
  `MBGS_ASSERT_IMPL(a_muted_silent, out_tvalid && out_tdata[0] && out_tdata[33], out_tdata[49:34] == '0)
  // A silent bus stays silent after the master product.
  `MBGS_ASSERT_IMPL(a_zero_gain, out_tvalid && out_tdata[0] && out_tdata[32:17] == '0, out_tdata[49:34] == '0)
  // Taking a command always leaves room in the queue on the next cycle.
  `MBGS_ASSERT_NEXT(a_pop_loads, pop, !q_status.full)

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the multi-bus gain smoother: directed table, then random words.
`timescale 1ns / 1ps

module testbench;

  localparam int NB          = mbgs_pkg::NUM_BUSES_DEF;
  localparam int MASTER      = mbgs_pkg::MASTER_INDEX_DEF;
  localparam int CYCLE_LIMIT = 400000;
  // A tick walks every bus, and two more words may sit in the queue.
  localparam int SETTLE      = 3 * (NB + 5) + 8;
  localparam int SEG_WORDS   = 117;

  // Input word, packed so that the last field lands in the lowest bits.
  typedef struct packed {
    logic [15:0] alpha;
    logic        mute;
    logic [15:0] gain;
    logic [3:0]  bus;
    logic [2:0]  cmd;
  } cmd_word_t;

  // Result word, same packing as out_tdata[49:0].
  typedef struct packed {
    logic [15:0] eff;
    logic        muted;
    logic [15:0] cur;
    logic [15:0] tgt;
    logic        valid;
  } report_t;

  typedef enum logic {ROW_WORD, ROW_LIMITS} row_kind_t;

  // A ROW_LIMITS row carries min_gain in the gain field and max_gain in the alpha field.
  typedef struct packed {
    row_kind_t kind;
    cmd_word_t w;
    logic      typed;
    report_t   want;
  } row_t;

  localparam report_t INVALID_REPORT = '{eff: mbgs_pkg::UNITY_GAIN, muted: 1'b0,
                                         cur: mbgs_pkg::UNITY_GAIN,
                                         tgt: mbgs_pkg::UNITY_GAIN, valid: 1'b0};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [mbgs_pkg::IN_W-1:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [mbgs_pkg::OUT_W-1:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Predictor state.
  logic [15:0] bus_cur [NB];
  logic [15:0] bus_tgt [NB];
  logic        bus_muted [NB];
  logic [15:0] gain_floor;
  logic [15:0] gain_ceil;

  report_t pending_reports[$];
  int      failures;
  int      cycles;
  int      tx_idle_pct;
  int      rx_idle_pct;

  multi_bus_gain_smoother #(
    .NUM_BUSES   (NB),
    .MASTER_INDEX(MASTER)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  function automatic logic [15:0] clamp_gain(logic [15:0] v);
    logic [15:0] g;
    g = (v < gain_floor) ? gain_floor : v;
    return (g > gain_ceil) ? gain_ceil : g;
  endfunction

  // One smoothing step: cur + floor(((tgt - cur) * alpha + 32768) / 65536).
  function automatic logic [15:0] smooth_toward(logic [15:0] cur, logic [15:0] tgt,
                                                logic [15:0] alpha);
    longint d;
    longint r;
    d = (longint'(tgt) - longint'(cur)) * longint'(alpha) + 64'sd32768;
    r = longint'(cur) + (d >>> 16);
    if (r < 0) r = 0;
    else if (r > 65535) r = 65535;
    return r[15:0];
  endfunction

  function automatic logic [15:0] effective_of(int b);
    logic [31:0] mcur;
    logic [31:0] prod;
    if (bus_muted[b]) return '0;
    if (b == MASTER) return bus_cur[b];
    if (MASTER < NB) begin
      if (bus_muted[MASTER % NB]) return '0;
      mcur = 32'(bus_cur[MASTER % NB]);
    end else begin
      mcur = 32'(mbgs_pkg::UNITY_GAIN);
    end
    prod = (32'(bus_cur[b]) * mcur + 32'd8192) >> 14;
    return (prod > 32'd65535) ? 16'hFFFF : prod[15:0];
  endfunction

  function automatic report_t apply_command(cmd_word_t w);
    report_t r;
    logic    ok;
    int      b;
    ok = (w.bus < NB);
    b  = int'(w.bus);
    if (w.cmd == mbgs_pkg::CMD_TICK) begin
      for (int i = 0; i < NB; i++) bus_cur[i] = smooth_toward(bus_cur[i], bus_tgt[i], w.alpha);
    end else if (ok) begin
      case (w.cmd)
        mbgs_pkg::CMD_SET_TARGET: bus_tgt[b] = clamp_gain(w.gain);
        mbgs_pkg::CMD_SET_IMMEDIATE: begin
          bus_tgt[b] = clamp_gain(w.gain);
          bus_cur[b] = bus_tgt[b];
        end
        mbgs_pkg::CMD_SET_MUTE: bus_muted[b] = w.mute;
        default: ;
      endcase
    end
    if (!ok) return INVALID_REPORT;
    r.valid = 1'b1;
    r.tgt   = bus_tgt[b];
    r.cur   = bus_cur[b];
    r.muted = bus_muted[b];
    r.eff   = effective_of(b);
    return r;
  endfunction

  function automatic report_t bus_report(logic v, logic [15:0] tgt, logic [15:0] cur,
                                         logic m, logic [15:0] eff);
    return '{eff: eff, muted: m, cur: cur, tgt: tgt, valid: v};
  endfunction

  function automatic row_t mk_row(row_kind_t k, logic [2:0] c, logic [3:0] b,
                                  logic [15:0] g, logic m, logic [15:0] a,
                                  logic typed, report_t want);
    return '{kind: k, w: '{alpha: a, mute: m, gain: g, bus: b, cmd: c},
             typed: typed, want: want};
  endfunction

  always @(posedge clk) begin : check_words
    report_t got;
    report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[49:0];
      check_field("padding", 0, out_tdata[mbgs_pkg::OUT_W-1:50]);
      if (pending_reports.size() == 0) begin
        $error("result word arrived with nothing expected");
        failures++;
      end else begin
        want = pending_reports.pop_front();
        check_field("bus_valid", want.valid, got.valid);
        check_field("target_gain_out", want.tgt, got.tgt);
        check_field("current_gain_out", want.cur, got.cur);
        check_field("muted_out", want.muted, got.muted);
        check_field("effective_gain", want.eff, got.eff);
      end
    end
  end

  task automatic idle_sender();
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_word(cmd_word_t w, logic typed, report_t want);
    report_t predicted;
    in_tdata  <= w;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predicted = apply_command(w);
    pending_reports.push_back(typed ? want : predicted);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes one register, then reads it back.
  task automatic write_reg(logic idx, logic [15:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {16'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == mbgs_pkg::REG_MAX_GAIN) gain_ceil = value;
    else gain_floor = value;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    check_field(idx == mbgs_pkg::REG_MAX_GAIN ? "max_gain" : "min_gain", value, cfg_prdata);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(logic [15:0] lo, logic [15:0] hi);
    write_reg(mbgs_pkg::REG_MIN_GAIN, lo);
    write_reg(mbgs_pkg::REG_MAX_GAIN, hi);
  endtask

  initial begin : stimulus
    row_t        plan[$];
    cmd_word_t   w;
    logic [15:0] lims_lo [6];
    logic [15:0] lims_hi [6];
    int          r;
    report_t     unity;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    failures    = 0;
    cycles      = 0;
    tx_idle_pct = 12;
    rx_idle_pct = 84;
    gain_floor  = 16'd0;
    gain_ceil   = 16'd32768;
    for (int i = 0; i < NB; i++) begin
      bus_cur[i]   = mbgs_pkg::UNITY_GAIN;
      bus_tgt[i]   = mbgs_pkg::UNITY_GAIN;
      bus_muted[i] = 1'b0;
    end
    unity = bus_report(1'b1, mbgs_pkg::UNITY_GAIN, mbgs_pkg::UNITY_GAIN, 1'b0,
                       mbgs_pkg::UNITY_GAIN);

    plan.push_back(mk_row(ROW_WORD, mbgs_pkg::CMD_QUERY, 4'd0, 16'd0, 1'b0, 16'd0, 1'b1,
                          unity));
    plan.push_back(mk_row(ROW_WORD, mbgs_pkg::CMD_QUERY, 4'd15, 16'd0, 1'b0, 16'd0, 1'b1,
                          INVALID_REPORT));
    // Unused command codes behave as a query.
    plan.push_back(mk_row(ROW_WORD, 3'd5, 4'd3, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, unity));
    plan.push_back(mk_row(ROW_WORD, 3'd7, 4'd8, 16'd0, 1'b0, 16'd0, 1'b1, INVALID_REPORT));
    plan.push_back(mk_row(ROW_WORD, mbgs_pkg::CMD_SET_TARGET, 4'd2, 16'hFFFF, 1'b0, 16'd0,
                          1'b1, bus_report(1'b1, 16'd32768, mbgs_pkg::UNITY_GAIN, 1'b0,
                                           mbgs_pkg::UNITY_GAIN)));
    plan.push_back(mk_row(ROW_WORD, mbgs_pkg::CMD_SET_IMMEDIATE, 4'd1, 16'd0, 1'b0, 16'd0,
                          1'b1, bus_report(1'b1, 16'd0, 16'd0, 1'b0, 16'd0)));
    plan.push_back(mk_row(ROW_WORD, mbgs_pkg::CMD_SET_MUTE, 4'd4, 16'd0, 1'b1, 16'd0, 1'b1,
                          bus_report(1'b1, mbgs_pkg::UNITY_GAIN, mbgs_pkg::UNITY_GAIN, 1'b1,
                                     16'd0)));
    plan.push_back(mk_row(ROW_WORD, mbgs_pkg::CMD_TICK, 4'd2, 16'd0, 1'b0, 16'd0, 1'b1,
                          bus_report(1'b1, 16'd32768, mbgs_pkg::UNITY_GAIN, 1'b0,
                                     mbgs_pkg::UNITY_GAIN)));
    plan.push_back(mk_row(ROW_WORD, mbgs_pkg::CMD_TICK, 4'd2, 16'd0, 1'b0, 16'hFFFF, 1'b0,
                          '0));
    // A tick addressed to a missing bus still moves every bus.
    plan.push_back(mk_row(ROW_WORD, mbgs_pkg::CMD_TICK, 4'd9, 16'd0, 1'b0, 16'd32768, 1'b1,
                          INVALID_REPORT));
    plan.push_back(mk_row(ROW_WORD, mbgs_pkg::CMD_SET_TARGET, 4'd8, 16'd0, 1'b0, 16'd0, 1'b1,
                          INVALID_REPORT));
    plan.push_back(mk_row(ROW_WORD, mbgs_pkg::CMD_SET_IMMEDIATE, 4'd12, 16'd999, 1'b0, 16'd0,
                          1'b1, INVALID_REPORT));
    plan.push_back(mk_row(ROW_WORD, mbgs_pkg::CMD_SET_MUTE, 4'd0, 16'd0, 1'b1, 16'd0, 1'b1,
                          bus_report(1'b1, mbgs_pkg::UNITY_GAIN, mbgs_pkg::UNITY_GAIN, 1'b1,
                                     16'd0)));
    // With the master muted every other bus reads zero.
    plan.push_back(mk_row(ROW_WORD, mbgs_pkg::CMD_QUERY, 4'd3, 16'd0, 1'b0, 16'd0, 1'b1,
                          bus_report(1'b1, mbgs_pkg::UNITY_GAIN, mbgs_pkg::UNITY_GAIN, 1'b0,
                                     16'd0)));
    plan.push_back(mk_row(ROW_WORD, mbgs_pkg::CMD_SET_MUTE, 4'd0, 16'd0, 1'b0, 16'd0, 1'b1,
                          unity));
    plan.push_back(mk_row(ROW_WORD, mbgs_pkg::CMD_SET_TARGET, 4'd6, 16'd0, 1'b0, 16'd0, 1'b0,
                          '0));
    plan.push_back(mk_row(ROW_WORD, mbgs_pkg::CMD_TICK, 4'd6, 16'd0, 1'b0, 16'd32768, 1'b0,
                          '0));
    plan.push_back(mk_row(ROW_LIMITS, mbgs_pkg::CMD_QUERY, 4'd0, 16'd16384, 1'b0, 16'hFFFF,
                          1'b0, '0));
    plan.push_back(mk_row(ROW_WORD, mbgs_pkg::CMD_SET_IMMEDIATE, 4'd0, 16'hFFFF, 1'b0, 16'd0,
                          1'b1, bus_report(1'b1, 16'hFFFF, 16'hFFFF, 1'b0, 16'hFFFF)));
    // The product of two near-4.0 gains saturates.
    plan.push_back(mk_row(ROW_WORD, mbgs_pkg::CMD_SET_IMMEDIATE, 4'd5, 16'hFFFF, 1'b0, 16'd0,
                          1'b1, bus_report(1'b1, 16'hFFFF, 16'hFFFF, 1'b0, 16'hFFFF)));
    plan.push_back(mk_row(ROW_WORD, mbgs_pkg::CMD_SET_TARGET, 4'd3, 16'd0, 1'b0, 16'd0, 1'b1,
                          bus_report(1'b1, mbgs_pkg::UNITY_GAIN, mbgs_pkg::UNITY_GAIN, 1'b0,
                                     16'hFFFF)));
    // Floor above ceiling: every write lands on the ceiling.
    plan.push_back(mk_row(ROW_LIMITS, mbgs_pkg::CMD_QUERY, 4'd0, 16'hFFFF, 1'b0, 16'd0, 1'b0,
                          '0));
    plan.push_back(mk_row(ROW_WORD, mbgs_pkg::CMD_SET_TARGET, 4'd7, 16'd40000, 1'b0, 16'd0,
                          1'b1, bus_report(1'b1, 16'd0, mbgs_pkg::UNITY_GAIN, 1'b0,
                                           16'hFFFF)));
    plan.push_back(mk_row(ROW_WORD, mbgs_pkg::CMD_SET_IMMEDIATE, 4'd4, 16'd40000, 1'b0, 16'd0,
                          1'b1, bus_report(1'b1, 16'd0, 16'd0, 1'b1, 16'd0)));
    plan.push_back(mk_row(ROW_LIMITS, mbgs_pkg::CMD_QUERY, 4'd0, 16'd0, 1'b0, 16'hFFFF, 1'b0,
                          '0));
    plan.push_back(mk_row(ROW_WORD, mbgs_pkg::CMD_SET_IMMEDIATE, 4'd0, 16'd16384, 1'b0, 16'd0,
                          1'b0, '0));
    plan.push_back(mk_row(ROW_WORD, mbgs_pkg::CMD_QUERY, 4'd7, 16'd0, 1'b0, 16'd0, 1'b0, '0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_LIMITS) begin
        drain();
        set_limits(plan[i].w.gain, plan[i].w.alpha);
      end else begin
        idle_sender();
        send_word(plan[i].w, plan[i].typed, plan[i].want);
      end
    end

    lims_lo = '{16'd0, 16'd4096, 16'($urandom_range(16384)), 16'd0,
                16'($urandom_range(65535)), 16'd0};
    lims_hi = '{16'hFFFF, 16'd40000, 16'($urandom_range(65535, 16384)), 16'd32768,
                16'($urandom_range(65535)), 16'hFFFF};

    for (int seg = 0; seg < 6; seg++) begin
      tx_idle_pct = (seg < 2) ? 12 : (seg < 4) ? 84 : 0;
      rx_idle_pct = (seg < 2) ? 84 : (seg < 4) ? 12 : 0;
      drain();
      set_limits(lims_lo[seg], lims_hi[seg]);
      for (int k = 0; k < SEG_WORDS; k++) begin
        r = $urandom_range(99);
        if (r < 20) w.cmd = mbgs_pkg::CMD_SET_TARGET;
        else if (r < 35) w.cmd = mbgs_pkg::CMD_SET_IMMEDIATE;
        else if (r < 47) w.cmd = mbgs_pkg::CMD_SET_MUTE;
        else if (r < 70) w.cmd = mbgs_pkg::CMD_TICK;
        else if (r < 90) w.cmd = mbgs_pkg::CMD_QUERY;
        else w.cmd = 3'($urandom_range(7, 5));
        w.bus = ($urandom_range(99) < 85) ? 4'($urandom_range(NB - 1))
                                          : 4'($urandom_range(15, NB));
        r = $urandom_range(99);
        w.gain = (r < 60) ? 16'($urandom_range(65535)) :
                 (r < 80) ? 16'($urandom_range(24576, 8192)) :
                 (r < 90) ? 16'd0 : 16'hFFFF;
        w.mute = ($urandom_range(99) < 40);
        r = $urandom_range(99);
        w.alpha = (r < 70) ? 16'($urandom_range(65535)) :
                  (r < 80) ? 16'd0 :
                  (r < 90) ? 16'hFFFF : 16'($urandom_range(2048, 1));
        // Hold the sender back once until the block has emptied out.
        if (seg == 1 && k == 60) drain();
        idle_sender();
        send_word(w, 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (failures == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
